// ----- rtl/core/lpxc_pkg.sv -----
// Shared constants, register indexes and controller/datapath interface types.
package lpxc_pkg;

  localparam int unsigned PASS_MAX = 16;
  localparam int unsigned LEN_W    = 5;
  localparam int unsigned IDX_W    = 4;

  localparam logic [31:0] LCG_MULT  = 32'd1103515245;
  localparam logic [31:0] LCG_INC   = 32'd12345;
  localparam logic [14:0] RND_LIMIT = 15'd25000;

  typedef enum logic [1:0] {
    REG_PASS_LOW  = 2'd0,
    REG_PASS_HIGH = 2'd1,
    REG_PASS_LEN  = 2'd2,
    REG_KEY       = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic capture;
    logic init_build;
    logic step_build;
    logic load_seed;
    logic mult;
    logic finish;
  } lpxc_cmd_t;

  typedef struct packed {
    logic need_build;
    logic build_done;
    logic out_free;
  } lpxc_status_t;

endpackage

// ----- rtl/core/lpxc_ctrl.sv -----
// Sequencer: accept, optional seed build, LCG multiply, result write.
module lpxc_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  output lpxc_pkg::lpxc_cmd_t  cmd,
  input  lpxc_pkg::lpxc_status_t status
);
  import lpxc_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BUILD,
    ST_MUL,
    ST_FIN
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_tvalid) begin
            state <= status.need_build ? ST_BUILD : ST_MUL;
          end
        end
        ST_BUILD: begin
          if (status.build_done) begin
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          state <= ST_FIN;
        end
        ST_FIN: begin
          if (status.out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    in_tready      = (state == ST_IDLE);
    cmd.capture    = (state == ST_IDLE) && in_tvalid;
    cmd.init_build = cmd.capture && status.need_build;
    cmd.step_build = (state == ST_BUILD) && !status.build_done;
    cmd.load_seed  = (state == ST_BUILD) && status.build_done;
    cmd.mult       = (state == ST_MUL);
    cmd.finish     = (state == ST_FIN) && status.out_free;
  end

  a_capture_path: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> (state == ST_BUILD || state == ST_MUL))
    else $error("captured transaction did not start processing");

  a_finish_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> (state == ST_IDLE))
    else $error("controller did not return to idle after result write");

  a_cmd_exclusive: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.capture, cmd.step_build, cmd.load_seed, cmd.mult, cmd.finish}))
    else $error("conflicting datapath commands");

endmodule

// ----- rtl/core/lpxc_dp.sv -----
// Datapath: config registers, seed builder, LCG stage and output register.
module lpxc_dp (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_index,
  input  logic [63:0]            cfg_data,
  input  logic [7:0]             in_data,
  input  logic                   in_restart,
  input  lpxc_pkg::lpxc_cmd_t    cmd,
  output lpxc_pkg::lpxc_status_t status,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [7:0]             out_tdata
);
  import lpxc_pkg::*;

  logic [63:0]        pass_low;
  logic [63:0]        pass_high;
  logic [LEN_W-1:0]   pass_length;
  logic [31:0]        cipher_key;

  logic [31:0]        seed;
  logic [IDX_W-1:0]   pass_index;
  logic               seed_pending;
  logic [LEN_W-1:0]   build_cnt;
  logic [31:0]        acc;
  logic [31:0]        prod;
  logic [7:0]         data;

  logic [LEN_W-1:0]   eff_len;
  logic [127:0]       pass_all;
  logic [7:0]         build_byte;
  logic [31:0]        seed_next;
  logic [14:0]        rnd;
  logic [IDX_W-1:0]   idx_use;
  logic [LEN_W-1:0]   idx_inc;
  logic [IDX_W-1:0]   pass_index_next;
  logic [7:0]         ks;

  assign eff_len  = (pass_length > LEN_W'(PASS_MAX)) ? LEN_W'(PASS_MAX) : pass_length;
  assign pass_all = {pass_high, pass_low};

  assign build_byte = pass_all[build_cnt[IDX_W-1:0]*8 +: 8];

  assign seed_next = prod + LCG_INC;
  assign rnd       = seed_next[30:16];

  // Wrap a stale index first, then advance and wrap at the length.
  always_comb begin
    idx_use = ({1'b0, pass_index} >= eff_len) ? '0 : pass_index;
    idx_inc = {1'b0, idx_use} + LEN_W'(1);
    pass_index_next = (idx_inc >= eff_len) ? '0 : idx_inc[IDX_W-1:0];
    if (rnd > RND_LIMIT) begin
      ks = (eff_len == '0) ? 8'd0 : pass_all[idx_use*8 +: 8];
    end else begin
      ks = rnd[7:0];
    end
  end

  assign status.need_build = in_restart || seed_pending;
  assign status.build_done = (build_cnt == eff_len);
  assign status.out_free   = !out_tvalid || out_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pass_low    <= '0;
      pass_high   <= '0;
      pass_length <= LEN_W'(1);
      cipher_key  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PASS_LOW:  pass_low    <= cfg_data;
        REG_PASS_HIGH: pass_high   <= cfg_data;
        REG_PASS_LEN:  pass_length <= cfg_data[LEN_W-1:0];
        REG_KEY:       cipher_key  <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seed         <= '0;
      pass_index   <= '0;
      seed_pending <= 1'b1;
      build_cnt    <= '0;
      out_tvalid   <= 1'b0;
    end else begin
      if (cmd.init_build) begin
        build_cnt <= '0;
      end else if (cmd.step_build) begin
        build_cnt <= build_cnt + LEN_W'(1);
      end
      if (cmd.load_seed) begin
        seed         <= acc;
        pass_index   <= '0;
        seed_pending <= 1'b0;
      end else if (cmd.finish) begin
        seed       <= seed_next;
        pass_index <= pass_index_next;
      end
      if (cmd.finish) begin
        out_tvalid <= 1'b1;
      end else if (out_tready) begin
        out_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      data <= in_data;
    end
    if (cmd.init_build) begin
      acc <= 32'(cipher_key * {{(32-LEN_W){1'b0}}, eff_len});
    end else if (cmd.step_build) begin
      acc <= acc + ({24'd0, build_byte} ^ cipher_key);
    end
    if (cmd.mult) begin
      prod <= 32'(seed * LCG_MULT);
    end
    if (cmd.finish) begin
      out_tdata <= data ^ ks;
    end
  end

  a_seed_loaded: assert property (@(posedge clk) disable iff (rst)
    cmd.load_seed |=> (!seed_pending && pass_index == '0))
    else $error("seed load left pending flag or index set");

  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.step_build |-> (build_cnt < eff_len))
    else $error("seed build stepped past the passphrase length");

  a_finish_out: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> out_tvalid)
    else $error("result write did not raise output valid");

endmodule

// ----- rtl/core/lcg_passphrase_xor_cipher_core.sv -----
// Top level of the passphrase-keyed LCG byte cipher.
// Each accepted byte is XORed with one keystream byte and gives one result.
// A byte goes through accept, LCG multiply and result write; when restart
// is set, or on the first byte after reset, the seed is rebuilt first by
// an adder that takes one passphrase byte per cycle, L bytes in all, L
// being the passphrase length in use (at most 16). The next byte is
// accepted while a result still waits on the output register.
// Configuration writes take effect at once and never start a reseed.
module lcg_passphrase_xor_cipher_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_in
  input  logic        s_axis_tuser,   // [0] restart
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata    // [7:0] data_out
);
  import lpxc_pkg::*;

  lpxc_cmd_t    cmd;
  lpxc_status_t status;

  lpxc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_tvalid (s_axis_tvalid),
    .in_tready (s_axis_tready),
    .cmd       (cmd),
    .status    (status)
  );

  lpxc_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_data    (s_axis_tdata),
    .in_restart (s_axis_tuser),
    .cmd        (cmd),
    .status     (status),
    .out_tvalid (m_axis_tvalid),
    .out_tready (m_axis_tready),
    .out_tdata  (m_axis_tdata)
  );

endmodule
